// ===== rtl/istt_pkg.sv =====
// Package for the instruction stream transfer tally.
// Holds widths, opcode codes, instruction kind type and the opcode length table.
// No dependencies.
`default_nettype none

package istt_pkg;

   localparam int TotalWidth = 32;   // width of the running totals, 25..64
   localparam int WordWidth  = 32;
   localparam int BankWidth  = 6;

   typedef logic [TotalWidth-1:0] total_type;
   typedef logic [WordWidth-1:0]  word_type;
   typedef logic [BankWidth-1:0]  bank_type;
   typedef logic [2:0]            pos_type;
   typedef logic [3:0]            opcode_type;

   localparam opcode_type OpLoad = 4'h0;
   localparam opcode_type OpSave = 4'h4;

   localparam bank_type ParamBankBaseReset = 6'd16;

   typedef enum logic [1:0] {
      KindOther = 2'd0,
      KindLoad  = 2'd1,
      KindSave  = 2'd2
   } kind_type;

   // Instruction length in words; zero marks an unknown opcode.
   function automatic pos_type op_words(input opcode_type op);
      pos_type n;
      unique case (op)
         4'h0:    n = 3'd5;
         4'h1:    n = 3'd6;
         4'h2:    n = 3'd5;
         4'h4:    n = 3'd5;
         4'h6:    n = 3'd2;
         4'h7:    n = 3'd1;
         4'h8:    n = 3'd5;
         4'h9:    n = 3'd4;
         4'hA:    n = 3'd5;
         4'hB:    n = 3'd3;
         4'hC:    n = 3'd5;
         4'hD:    n = 3'd3;
         4'hE:    n = 3'd3;
         default: n = 3'd0;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/istt_if.sv =====
// Channel interfaces for the instruction stream transfer tally.
// Uses istt_pkg for payload types.
`default_nettype none

interface istt_req_if;
   logic               valid;
   logic               ready;
   istt_pkg::word_type code_word;
   logic               last_word;

   modport source (output valid, output code_word, output last_word, input ready);
   modport sink   (input valid, input code_word, input last_word, output ready);
endinterface

interface istt_rsp_if;
   logic                valid;
   logic                ready;
   istt_pkg::word_type  load_image_total;
   istt_pkg::word_type  load_param_total;
   istt_pkg::word_type  save_total;
   logic                bad_opcode;
   logic                final_totals;

   modport source (output valid, output load_image_total, output load_param_total,
                   output save_total, output bad_opcode, output final_totals,
                   input ready);
   modport sink   (input valid, input load_image_total, input load_param_total,
                   input save_total, input bad_opcode, input final_totals,
                   output ready);
endinterface

interface istt_csr_if;
   logic               valid;
   logic               ready;
   istt_pkg::bank_type param_bank_base;

   modport source (output valid, output param_bank_base, input ready);
   modport sink   (input valid, input param_bank_base, output ready);
endinterface

`default_nettype wire

// ===== rtl/instruction_stream_transfer_tally.sv =====
// Instruction stream transfer tally: walks a machine-code stream one word per
// transfer and keeps running load/save size totals.
// Depends on istt_pkg and the channel interfaces in istt_if.sv.
//
// Usage:
//   req_ch  - one 32-bit code word per transfer, last_word marks program end.
//   rsp_ch  - one result per code word: the three totals after that word,
//             bad_opcode for a head word with an unknown opcode, and
//             final_totals echoing last_word. Totals clear after a last word.
//   csr_ch  - writes param_bank_base (always ready); write only while idle.
// Path: a word taken on req_ch passes two register stages (input register,
//   result register) before its result appears on rsp_ch.
// Throughput: one word per cycle unless rsp_ch stalls; the whole parse step and the 11x15 bit
//   size multiply-accumulate sit between the input and result registers.
// Reset (synchronous, active high) empties both stages, clears totals and
//   parse position and sets param_bank_base to 16.
// When the receiver stalls, the result register holds and the input register
//   still takes one more word; further words wait until rsp_ch moves.
`default_nettype none

module instruction_stream_transfer_tally (
   input  wire logic    clock,
   input  wire logic    reset,
   istt_req_if.sink     req_ch,
   istt_rsp_if.source   rsp_ch,
   istt_csr_if.sink     csr_ch
);

   // configuration
   istt_pkg::bank_type  param_bank_base_ff;

   // input register
   logic                s1_vld_ff;
   istt_pkg::word_type  s1_word_ff;
   logic                s1_last_ff;

   // parse state
   istt_pkg::pos_type   pos_ff,   pos_in;
   istt_pkg::pos_type   words_ff, words_in;
   istt_pkg::kind_type  kind_ff,  kind_in;
   logic                param_bank_ff, param_bank_in;
   istt_pkg::total_type image_sum_ff, image_sum_in;
   istt_pkg::total_type param_sum_ff, param_sum_in;
   istt_pkg::total_type store_sum_ff, store_sum_in;

   // result register
   logic                rsp_vld_ff;
   istt_pkg::word_type  rsp_image_ff, rsp_param_ff, rsp_store_ff;
   logic                rsp_bad_ff, rsp_final_ff;

   logic                adv;
   logic                req_take;
   logic                head;
   istt_pkg::opcode_type op;
   istt_pkg::pos_type   op_len;
   logic                bad;
   istt_pkg::pos_type   pos_inc;
   istt_pkg::pos_type   words_sel;
   logic [10:0]         len_p1;
   logic [13:0]         chan_raw;
   logic [14:0]         chan_p1;
   logic [25:0]         prod;
   istt_pkg::total_type prod_ext;

   assign adv      = s1_vld_ff && (!rsp_vld_ff || rsp_ch.ready);
   assign req_take = req_ch.valid && req_ch.ready;

   assign req_ch.ready = !s1_vld_ff || adv;
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid            = rsp_vld_ff;
   assign rsp_ch.load_image_total = rsp_image_ff;
   assign rsp_ch.load_param_total = rsp_param_ff;
   assign rsp_ch.save_total       = rsp_store_ff;
   assign rsp_ch.bad_opcode       = rsp_bad_ff;
   assign rsp_ch.final_totals     = rsp_final_ff;

   // parse step for the word in the input register
   always_comb begin
      head     = (pos_ff == 3'd0);
      op       = s1_word_ff[31:28];
      op_len   = istt_pkg::op_words(op);
      bad      = head && (op_len == 3'd0);

      len_p1   = {1'b0, s1_word_ff[9:0]} + 11'd1;
      chan_raw = (kind_ff == istt_pkg::KindSave) ? {2'b00, s1_word_ff[21:10]}
                                                 : s1_word_ff[23:10];
      chan_p1  = {1'b0, chan_raw} + 15'd1;
      prod     = 26'(len_p1) * 26'(chan_p1);
      prod_ext = istt_pkg::total_type'(prod);

      words_in      = words_ff;
      kind_in       = kind_ff;
      param_bank_in = param_bank_ff;
      image_sum_in  = image_sum_ff;
      param_sum_in  = param_sum_ff;
      store_sum_in  = store_sum_ff;

      if (head) begin
         words_in = (op_len == 3'd0) ? 3'd1 : op_len;
         if (op == istt_pkg::OpLoad) begin
            kind_in = istt_pkg::KindLoad;
         end else if (op == istt_pkg::OpSave) begin
            kind_in = istt_pkg::KindSave;
         end else begin
            kind_in = istt_pkg::KindOther;
         end
         param_bank_in = (s1_word_ff[19:14] >= param_bank_base_ff);
      end else if (pos_ff == 3'd2) begin
         if (kind_ff == istt_pkg::KindLoad) begin
            if (param_bank_ff) begin
               param_sum_in = param_sum_ff + prod_ext;
            end else begin
               image_sum_in = image_sum_ff + prod_ext;
            end
         end else if (kind_ff == istt_pkg::KindSave) begin
            store_sum_in = store_sum_ff + prod_ext;
         end
      end

      pos_inc   = pos_ff + 3'd1;
      words_sel = words_in;
      pos_in    = (pos_inc >= words_sel) ? 3'd0 : pos_inc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         param_bank_base_ff <= istt_pkg::ParamBankBaseReset;
         s1_vld_ff          <= 1'b0;
         rsp_vld_ff         <= 1'b0;
         pos_ff             <= '0;
         words_ff           <= '0;
         kind_ff            <= istt_pkg::KindOther;
         param_bank_ff      <= 1'b0;
         image_sum_ff       <= '0;
         param_sum_ff       <= '0;
         store_sum_ff       <= '0;
      end else begin
         if (csr_ch.valid) begin
            param_bank_base_ff <= csr_ch.param_bank_base;
         end

         if (req_take) begin
            s1_vld_ff <= 1'b1;
         end else if (adv) begin
            s1_vld_ff <= 1'b0;
         end

         if (adv) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_vld_ff <= 1'b0;
         end

         if (adv) begin
            if (s1_last_ff) begin
               // end of program: drop any open instruction and clear the totals
               pos_ff        <= '0;
               words_ff      <= '0;
               kind_ff       <= istt_pkg::KindOther;
               param_bank_ff <= 1'b0;
               image_sum_ff  <= '0;
               param_sum_ff  <= '0;
               store_sum_ff  <= '0;
            end else begin
               pos_ff        <= pos_in;
               words_ff      <= words_in;
               kind_ff       <= kind_in;
               param_bank_ff <= param_bank_in;
               image_sum_ff  <= image_sum_in;
               param_sum_ff  <= param_sum_in;
               store_sum_ff  <= store_sum_in;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_word_ff <= req_ch.code_word;
         s1_last_ff <= req_ch.last_word;
      end
      if (adv) begin
         rsp_image_ff <= 32'(image_sum_in);
         rsp_param_ff <= 32'(param_sum_in);
         rsp_store_ff <= 32'(store_sum_in);
         rsp_bad_ff   <= bad;
         rsp_final_ff <= s1_last_ff;
      end
   end

   // no instruction is longer than six words
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= 3'd5)
      else $error("parse position out of range");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (adv && s1_last_ff) |=> (pos_ff == 3'd0 && image_sum_ff == '0 &&
                               param_sum_ff == '0 && store_sum_ff == '0))
      else $error("state not cleared after last word");

   a_sums_only_word2: assert property (@(posedge clock) disable iff (reset)
      (adv && !s1_last_ff && pos_ff != 3'd2) |=>
         ($stable(image_sum_ff) && $stable(param_sum_ff) && $stable(store_sum_ff)))
      else $error("total changed away from word two");

   a_bad_head_only: assert property (@(posedge clock) disable iff (reset)
      (adv && !head) |=> !rsp_bad_ff)
      else $error("bad opcode flagged on a non-head word");

endmodule

`default_nettype wire
